/* design/utcep_pkg.sv */
// Package for the UTC calendar to epoch seconds core.
// Holds the time constants, register addresses and the cumulative month table.
// Has no dependencies; every design file imports it.
package utcep_pkg;

	// Time constants.
	localparam logic [31:0] SEC_PER_MIN  = 32'd60;
	localparam logic [31:0] SEC_PER_HOUR = 32'd3600;
	localparam logic [31:0] SEC_PER_DAY  = 32'd86400;
	localparam logic [33:0] NS_PER_SEC   = 34'd1000000000;

	// Calendar constants.
	localparam int unsigned TWO_DIGIT_MAX  = 37;
	localparam int unsigned FULL_YEAR_MIN  = 1900;
	localparam int unsigned DAYS_PER_YEAR  = 365;
	localparam int unsigned EPOCH_TM_YEAR  = 70;
	localparam int unsigned LEAP_TM_BASE   = 69;
	localparam int unsigned CENTURY_COUNT  = 41;

	// Configuration register map (word index taken from paddr[2]).
	localparam int unsigned PADDR_W        = 3;
	localparam logic        REG_SECOND_OFS = 1'b0;

	// Field widths.
	localparam int unsigned OFFSET_W = 18;
	localparam int unsigned DAYS_W   = 22;

	typedef logic signed [DAYS_W-1:0] days_t;
	typedef logic signed [2:0]        carry_t;

	// Date path results handed to the top level.
	typedef struct packed {
		days_t days;
		logic  bad_month;
	} date_res_t;

	// Days before the first of the given month; months out of range give zero.
	function automatic logic [8:0] cum_days(input logic [3:0] mon, input logic leap);
		logic [8:0] base;
		case (mon)
			4'd1:    base = 9'd0;
			4'd2:    base = 9'd31;
			4'd3:    base = 9'd59;
			4'd4:    base = 9'd90;
			4'd5:    base = 9'd120;
			4'd6:    base = 9'd151;
			4'd7:    base = 9'd181;
			4'd8:    base = 9'd212;
			4'd9:    base = 9'd243;
			4'd10:   base = 9'd273;
			4'd11:   base = 9'd304;
			4'd12:   base = 9'd334;
			default: base = 9'd0;
		endcase
		if (leap && (mon >= 4'd3) && (mon <= 4'd12)) begin
			base = base + 9'd1;
		end
		return base;
	endfunction

endpackage

/* design/utcep_date.sv */
// Date path: year mapping, Gregorian leap test, day of year and day count.
// Gives the whole days since the epoch (with the simple leap-day count).
// Depends on utcep_pkg.
module utcep_date
	import utcep_pkg::*;
(
	input  logic [11:0] calendar_year,
	input  logic [3:0]  month_number,
	input  logic [4:0]  day_of_month,
	output date_res_t   res
);

	logic [11:0]        tm_year;
	logic [11:0]        full_year;
	logic               century;
	logic               quad_century;
	logic               leap;
	logic               bad;
	logic signed [10:0] yday;
	logic signed [12:0] ld_diff;
	logic signed [12:0] leap_days;
	logic signed [12:0] years;
	logic signed [DAYS_W-1:0] year_days;

	// Map two-digit years, full years and years since 1900 to years since 1900 and to the full year.
	always_comb begin
		if (calendar_year <= 12'(TWO_DIGIT_MAX)) begin
			tm_year   = calendar_year + 12'd100;
			full_year = calendar_year + 12'd2000;
		end else if (calendar_year >= 12'(FULL_YEAR_MIN)) begin
			tm_year   = calendar_year - 12'(FULL_YEAR_MIN);
			full_year = calendar_year;
		end else begin
			tm_year   = calendar_year;
			full_year = calendar_year + 12'(FULL_YEAR_MIN);
		end
	end

	// Century years in range are matched against a short list of constants.
	always_comb begin
		century      = 1'b0;
		quad_century = 1'b0;
		for (int c = 0; c < CENTURY_COUNT; c++) begin
			if (full_year == 12'(c * 100)) begin
				century = 1'b1;
				if ((c % 4) == 0) begin
					quad_century = 1'b1;
				end
			end
		end
	end

	assign leap = (full_year[1:0] == 2'b00) && (!century || quad_century);
	assign bad  = (month_number == 4'd0) || (month_number > 4'd12);

	// Day of year; a bad month counts only the day field.
	always_comb begin
		yday = $signed({6'b0, day_of_month}) - 11'sd1;
		if (!bad) begin
			yday = yday + $signed({2'b0, cum_days(month_number, leap)});
		end
	end

	// Leap days as (tm_year - 69) / 4 truncated toward zero.
	always_comb begin
		ld_diff = $signed({1'b0, tm_year}) - $signed(13'(LEAP_TM_BASE));
		if (ld_diff < 0) begin
			leap_days = (ld_diff + 13'sd3) >>> 2;
		end else begin
			leap_days = ld_diff >>> 2;
		end
	end

	// Total days since the epoch.
	assign years     = $signed({1'b0, tm_year}) - 13'(EPOCH_TM_YEAR);
	assign year_days = DAYS_W'(years) * DAYS_W'(DAYS_PER_YEAR);

	assign res.days      = year_days + DAYS_W'(yday) + DAYS_W'(leap_days);
	assign res.bad_month = bad;

endmodule

/* design/utcep_nsnorm.sv */
// Nanosecond normalization: floor division of a signed 32-bit count by 10^9.
// The quotient lies in -3..2, so it is found by threshold compares.
// Depends on utcep_pkg.
module utcep_nsnorm
	import utcep_pkg::*;
(
	input  logic signed [31:0] nanoseconds_in,
	output carry_t             carry,
	output logic [29:0]        nanoseconds_out
);

	logic signed [33:0] ns_w;
	logic signed [33:0] ns_sec;
	logic signed [33:0] rem_w;

	assign ns_w = 34'(nanoseconds_in);

	// Pick the floor quotient from the value's band.
	always_comb begin
		if (ns_w < -34'sd2000000000) begin
			carry = -3'sd3;
		end else if (ns_w < -34'sd1000000000) begin
			carry = -3'sd2;
		end else if (ns_w < 34'sd0) begin
			carry = -3'sd1;
		end else if (ns_w < 34'sd1000000000) begin
			carry = 3'sd0;
		end else if (ns_w < 34'sd2000000000) begin
			carry = 3'sd1;
		end else begin
			carry = 3'sd2;
		end
	end

	// Whole seconds in nanoseconds for the chosen quotient.
	always_comb begin
		case (carry)
			-3'sd3:  ns_sec = -$signed(NS_PER_SEC) * 34'sd3;
			-3'sd2:  ns_sec = -$signed(NS_PER_SEC) * 34'sd2;
			-3'sd1:  ns_sec = -$signed(NS_PER_SEC);
			3'sd1:   ns_sec = $signed(NS_PER_SEC);
			3'sd2:   ns_sec = $signed(NS_PER_SEC) * 34'sd2;
			default: ns_sec = 34'sd0;
		endcase
	end

	assign rem_w           = ns_w - ns_sec;
	assign nanoseconds_out = rem_w[29:0];

endmodule

/* design/utc_calendar_to_epoch_seconds_core.sv */
// Top level of the UTC calendar to epoch seconds core.
// Holds the APB register, the input and result registers and the seconds sum.
// Depends on utcep_pkg, utcep_date and utcep_nsnorm.
//
// Order: a word accepted at a clock edge goes into the input register, then its result goes into the
// result register and appears on the result ports, with done high for a single cycle.
// Throughput: one word per cycle; the input register and result register form
// a two-stage pipeline and busy stays low. The receiver cannot stall results.
// Reset clears the pipeline valid bits and sets second_offset to zero.
module utc_calendar_to_epoch_seconds_core
	import utcep_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	// APB configuration port
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [PADDR_W-1:0]  paddr,
	input  logic [31:0]         pwdata,
	output logic [31:0]         prdata,
	output logic                pready,
	// Command interface
	input  logic                start,
	output logic                busy,
	input  logic [11:0]         calendar_year,
	input  logic [3:0]          month_number,
	input  logic [4:0]          day_of_month,
	input  logic [4:0]          hour_of_day,
	input  logic [5:0]          minute_of_hour,
	input  logic [5:0]          second_of_minute,
	input  logic signed [31:0]  nanoseconds_in,
	// Results
	output logic                done,
	output logic signed [31:0]  epoch_seconds,
	output logic [29:0]         nanoseconds_out,
	output logic                bad_month
);

	logic signed [OFFSET_W-1:0] offset_q;
	logic                       valid_s1;
	logic [11:0]                year_s1;
	logic [3:0]                 month_s1;
	logic [4:0]                 day_s1;
	logic [4:0]                 hour_s1;
	logic [5:0]                 minute_s1;
	logic [5:0]                 second_s1;
	logic signed [31:0]         ns_s1;
	logic                       done_s2;
	logic [31:0]                seconds_s2;
	logic [29:0]                nsec_s2;
	logic                       bad_s2;
	date_res_t                  date_res;
	carry_t                     carry;
	logic [29:0]                nsec_norm;
	logic                       cfg_write;
	logic [31:0]                day_sec;
	logic [31:0]                total_sec;

	assign busy   = 1'b0;
	assign pready = 1'b1;

	// Configuration register write and read back.
	assign cfg_write = psel && penable && pwrite && pready && (paddr[2] == REG_SECOND_OFS);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_q <= '0;
		end else if (cfg_write) begin
			offset_q <= pwdata[OFFSET_W-1:0];
		end
	end

	assign prdata = (paddr[2] == REG_SECOND_OFS) ? 32'(offset_q) : 32'd0;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			year_s1   <= calendar_year;
			month_s1  <= month_number;
			day_s1    <= day_of_month;
			hour_s1   <= hour_of_day;
			minute_s1 <= minute_of_hour;
			second_s1 <= second_of_minute;
			ns_s1     <= nanoseconds_in;
		end
	end

	// Date and nanosecond paths.
	utcep_date u_date (
		.calendar_year (year_s1),
		.month_number  (month_s1),
		.day_of_month  (day_s1),
		.res           (date_res)
	);

	utcep_nsnorm u_nsnorm (
		.nanoseconds_in  (ns_s1),
		.carry           (carry),
		.nanoseconds_out (nsec_norm)
	);

	// Seconds sum, taken modulo 2^32.
	assign day_sec   = 32'(date_res.days) * SEC_PER_DAY;
	assign total_sec = day_sec
	                 + ({27'b0, hour_s1} * SEC_PER_HOUR)
	                 + ({26'b0, minute_s1} * SEC_PER_MIN)
	                 + {26'b0, second_s1}
	                 + 32'(offset_q)
	                 + 32'(carry);

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_s2 <= 1'b0;
		end else begin
			done_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			seconds_s2 <= total_sec;
			nsec_s2    <= nsec_norm;
			bad_s2     <= date_res.bad_month;
		end
	end

	assign done            = done_s2;
	assign epoch_seconds   = $signed(seconds_s2);
	assign nanoseconds_out = nsec_s2;
	assign bad_month       = bad_s2;

	// Every accepted word gives exactly one result, through the input register and then the result register.
	a_valid_to_done: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |=> done)
		else $error("accepted word produced no result");

	a_no_spurious_done: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |=> !done)
		else $error("result strobe without an accepted word");

	// Normalized nanoseconds stay below one second.
	a_ns_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (nanoseconds_out < 30'd1000000000))
		else $error("nanoseconds out of range");

	// The month flag follows the registered month field.
	a_bad_month: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |=> (bad_month == (($past(month_s1) == 4'd0) || ($past(month_s1) > 4'd12))))
		else $error("bad month flag mismatch");

endmodule
